@@ rtl/rob_pkg.sv @@
// Shared constants, types and slot arithmetic for the in-order reorder buffer.
// No dependencies; imported by every module of the block.
`default_nettype none
package rob_pkg;

   localparam int WINDOW       = 32;
   localparam int PAYLOAD_BITS = 32;
   localparam int MAX_RESULTS  = 32;
   localparam int SEQ_W        = 16;
   localparam int IO_PAY_W     = 32;
   localparam int SLOT_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W        = $clog2(MAX_RESULTS + 1);
   localparam int QDEPTH       = 2;
   localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W       = $clog2(QDEPTH + 1);

   localparam logic [SEQ_W-1:0] RESET_FIRST = SEQ_W'(1);

   localparam logic STATUS_DELIVERED = 1'b0;
   localparam logic STATUS_REJECTED  = 1'b1;

   typedef struct packed {
      logic [SEQ_W-1:0]        seq;
      logic [PAYLOAD_BITS-1:0] payload;
   } item_type;

   typedef struct packed {
      logic [SEQ_W-1:0]    seq;
      logic [IO_PAY_W-1:0] payload;
      logic                status;
      logic                last;
   } result_type;

   // (base + step) mod WINDOW, both operands below WINDOW
   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [SLOT_W-1:0] step);
      logic [SLOT_W:0] sum;
      sum = {1'b0, base} + {1'b0, step};
      if (sum >= (SLOT_W+1)'(WINDOW)) begin
         sum = sum - (SLOT_W+1)'(WINDOW);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/rob_front.sv @@
// Front end: takes request beats and queues them.
// Depends on rob_pkg.
`default_nettype none
module rob_front
   import rob_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire item_type req_item,
   output logic          q_valid,
   output item_type      q_item,
   input  wire logic     q_pop
);

   item_type             q_mem [QDEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 push, pop;

   assign req_ready = (count_ff != QCNT_W'(QDEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_mem[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= req_item;
      end
   end

endmodule
`default_nettype wire

@@ rtl/rob_back.sv @@
// Back end: window check, slot ring with valid bits, in-order drain and
// the result register. Depends on rob_pkg.
`default_nettype none
module rob_back
   import rob_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic [SEQ_W-1:0] csr_data,
   input  wire logic             q_valid,
   input  wire item_type         q_item,
   output logic                  q_pop,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output result_type            rsp_result
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                    state_ff, state_in;
   logic [SEQ_W-1:0]        expected_ff, expected_in;
   logic [SLOT_W-1:0]       head_ff, head_in;
   logic [WINDOW-1:0]       valid_ff, valid_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, rsp_in;
   logic [PAYLOAD_BITS-1:0] slot_mem [WINDOW];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;

   logic              can_load;
   logic [SEQ_W-1:0]  offset;
   logic              in_win;
   logic [SLOT_W-1:0] slot;
   logic [SLOT_W-1:0] head_next;
   logic              wr_en;
   logic              last;

   assign can_load   = !rsp_valid_ff || rsp_ready;
   assign offset     = q_item.seq - expected_ff;
   assign in_win     = (offset < SEQ_W'(WINDOW));
   assign slot       = slot_add(head_ff, offset[SLOT_W-1:0]);
   assign head_next  = slot_add(head_ff, SLOT_W'(1));
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      expected_in  = expected_ff;
      head_in      = head_ff;
      valid_in     = valid_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      last         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && can_load) begin
               q_pop = 1'b1;
               if (in_win && !valid_ff[slot]) begin
                  wr_en          = 1'b1;
                  valid_in[slot] = 1'b1;
                  cnt_in         = '0;
                  if ((slot == head_ff) || valid_ff[head_ff]) begin
                     state_in = ST_DRAIN;
                  end
               end else begin
                  last           = !valid_ff[head_ff] || (MAX_RESULTS == 1);
                  rsp_valid_in   = 1'b1;
                  rsp_in.seq     = q_item.seq;
                  rsp_in.payload = '0;
                  rsp_in.status  = STATUS_REJECTED;
                  rsp_in.last    = last;
                  cnt_in         = CNT_W'(1);
                  if (!last) begin
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (can_load) begin
               if (valid_ff[head_ff] && (cnt_ff < CNT_W'(MAX_RESULTS))) begin
                  last = !valid_ff[head_next] ||
                         (CNT_W'(cnt_ff + 1'b1) == CNT_W'(MAX_RESULTS));
                  rsp_valid_in      = 1'b1;
                  rsp_in.seq        = expected_ff;
                  rsp_in.payload    = IO_PAY_W'(rd_data_ff);
                  rsp_in.status     = STATUS_DELIVERED;
                  rsp_in.last       = last;
                  valid_in[head_ff] = 1'b0;
                  expected_in       = expected_ff + 1'b1;
                  head_in           = head_next;
                  cnt_in            = CNT_W'(cnt_ff + 1'b1);
                  if (last) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_valid) begin
         state_in    = ST_IDLE;
         expected_in = csr_data;
         head_in     = '0;
         valid_in    = '0;
         cnt_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         expected_ff  <= RESET_FIRST;
         head_ff      <= '0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expected_ff  <= expected_in;
         head_ff      <= head_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // payload store; read port follows the next head, write data bypassed
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[slot] <= q_item.payload;
      end
      if (wr_en && (slot == head_in)) begin
         rd_data_ff <= q_item.payload;
      end else begin
         rd_data_ff <= slot_mem[head_in];
      end
   end

endmodule
`default_nettype wire

@@ rtl/in_order_reorder_buffer.sv @@
// Top level of the in-order reorder buffer: stream ports and packing.
// Depends on rob_pkg, rob_front and rob_back.
//
// Usage:
//   req_* carries numbered messages in any order. Each beat is either held in
//   a ring of WINDOW slots, or rejected at once when its number is stale,
//   already held or beyond the window.
//   rsp_* delivers messages strictly in sequence order. Once the expected
//   number is held, it and every consecutive held message leave one beat per
//   cycle while rsp_tready is high; tlast marks the final beat caused by one
//   request beat. A rejected beat (status 1, zero payload) precedes any drain.
//   csr_* loads the first expected number, empties the ring and resets the
//   ring head; write it only while the block is idle. csr_ready is always high.
// Timing:
//   A request beat is first held in the input queue. The back end pops it in the
//   idle state and either loads a reject into the result register or stores it,
//   entering the drain state when the head slot is held to deliver results.
// Reset: expected number 1, all slots empty, no beat pending.
// Back-pressure: rsp_tready low holds the result register; the back end
//   stops, and the two-entry input queue fills before req_tready falls.
`default_nettype none
module in_order_reorder_buffer
   import rob_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // [15:0] seq_number, [47:16] payload
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [15:0] out_seq, [47:16] out_payload
   output logic             rsp_tuser,   // [0] status
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);

   item_type   req_item;
   item_type   q_item;
   logic       q_valid;
   logic       q_pop;
   result_type rsp_result;

   assign req_item.seq     = req_tdata[SEQ_W-1:0];
   assign req_item.payload = PAYLOAD_BITS'(req_tdata[SEQ_W +: IO_PAY_W]);
   assign csr_ready        = 1'b1;

   rob_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_item  (req_item),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   rob_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {rsp_result.payload, rsp_result.seq};
   assign rsp_tuser = rsp_result.status;
   assign rsp_tlast = rsp_result.last;

endmodule
`default_nettype wire
